FILE: sv/dpa_pkg.sv
// Shared types and constants for the delta patch applier.
`timescale 1ns / 1ps

package dpa_pkg;

    // Field and state widths.
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 16;
    localparam int WORD_W     = 64;
    localparam int MAG_W      = 63;
    localparam int LEN_W      = 32;
    localparam int OLD_LEN_W  = 17;
    localparam int POS_W      = 64;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NEW_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OLD_LENGTH = CFG_IDX_W'(1);

    // Input item kinds.
    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_CTRL = 2'd1,
        FUNC_DATA = 2'd2,
        FUNC_RSVD = 2'd3
    } func_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CORRUPT = 2'd1,
        ST_TURN    = 2'd2
    } status_t;

    // Position within a control triple and its data run.
    typedef enum logic [1:0] {
        SLOT_ADD  = 2'd0,
        SLOT_COPY = 2'd1,
        SLOT_SEEK = 2'd2,
        SLOT_DATA = 2'd3
    } slot_t;

endpackage

FILE: sv/dpa_if.sv
// Valid/ready channel interfaces for items, results and configuration writes.
`timescale 1ns / 1ps

interface dpa_cmd_if import dpa_pkg::*; ();
    logic                valid;
    logic                ready;
    func_t               func;
    logic [ADDR_W-1:0]   old_address;
    logic [BYTE_W-1:0]   old_byte;
    logic [WORD_W-1:0]   control_word;
    logic [BYTE_W-1:0]   patch_byte;

    modport source (output valid, func, old_address, old_byte, control_word, patch_byte,
                    input ready);
    modport sink (input valid, func, old_address, old_byte, control_word, patch_byte,
                  output ready);
endinterface

interface dpa_res_if import dpa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_byte;
    status_t             status;
    logic                last;

    modport source (output valid, out_byte, status, last, input ready);
    modport sink (input valid, out_byte, status, last, output ready);
endinterface

interface dpa_cfg_if import dpa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/delta_patch_apply.sv
// Streaming binary delta patch applier: top level.
// Each result passes through stage one and then the output register.
// Throughput: one item per cycle unless the output stalls; old image read when ready.
// Loads and control words that end without error produce no result.
// Reset clears all control state at once; the old image memory is not cleared.
`timescale 1ns / 1ps

module delta_patch_apply import dpa_pkg::*; #(
    parameter int OLD_DEPTH = 65536
) (
    input  logic      clk,
    input  logic      rst_n,
    dpa_cmd_if.sink   cmd,
    dpa_res_if.source result,
    dpa_cfg_if.sink   cfg
);

    localparam int AW = $clog2(OLD_DEPTH);
    localparam int CW = (AW + 1 > OLD_LEN_W) ? AW + 1 : OLD_LEN_W;

    // Configuration registers.
    logic [LEN_W-1:0]     new_length_reg;
    logic [OLD_LEN_W-1:0] old_length_reg;

    // Control state.
    slot_t            slot_reg, slot_next;
    logic [LEN_W-1:0] add_remaining_reg, add_remaining_next;
    logic [LEN_W-1:0] copy_remaining_reg, copy_remaining_next;
    logic [POS_W-1:0] pending_seek_reg, pending_seek_next;
    logic [POS_W-1:0] old_position_reg, old_position_next;
    logic [LEN_W-1:0] new_position_reg, new_position_next;
    logic             failed_reg, failed_next;

    // Stage one (memory read in flight) and output register.
    logic              s1_valid_reg;
    status_t           s1_status_reg;
    logic [BYTE_W-1:0] s1_patch_reg;
    logic              s1_use_old_reg;
    logic              s1_last_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    status_t           out_status_reg;
    logic              out_last_reg;

    // Decode signals.
    logic              cmd_acc;
    logic              s1_go;
    logic [MAG_W-1:0]  mag;
    logic              neg;
    logic              mag_hi;
    logic [LEN_W-1:0]  room;
    logic [LEN_W:0]    room_left;
    logic              slot0_bad;
    logic              slot1_bad;
    logic [POS_W-1:0]  seek_word;
    logic [POS_W-1:0]  seek_value;
    logic [CW-1:0]     pos_lo;
    logic              in_range;
    logic [CW-1:0]     load_addr;
    logic              mem_we;
    logic [BYTE_W-1:0] mem_rdata;
    logic [POS_W-1:0]  pos_operand;
    logic              pos_cin;
    logic              pos_update;
    logic              res_valid;
    status_t           res_status;
    logic [BYTE_W-1:0] res_patch;
    logic              res_use_old;
    logic              res_last;
    logic              run_done;

    // Handshakes: a new item enters whenever stage one is free or moving on.
    assign cmd_acc   = cmd.valid & cmd.ready;
    assign s1_go     = ~out_valid_reg | result.ready;
    assign cmd.ready = ~s1_valid_reg | s1_go;
    assign cfg.ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            new_length_reg <= '0;
            old_length_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_NEW_LENGTH: new_length_reg <= cfg.data[LEN_W-1:0];
                REG_OLD_LENGTH: old_length_reg <= cfg.data[OLD_LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Control word decoding and length checks.
    always_comb
    begin
        mag        = cmd.control_word[MAG_W-1:0];
        neg        = cmd.control_word[WORD_W-1] & (mag != '0);
        mag_hi     = |mag[MAG_W-1:LEN_W];
        room       = (new_position_reg < new_length_reg) ?
                     (new_length_reg - new_position_reg) : '0;
        room_left  = {1'b0, room} - {1'b0, add_remaining_reg};
        slot0_bad  = neg | mag_hi | (mag[LEN_W-1:0] > room);
        slot1_bad  = neg | (~room_left[LEN_W] & (mag_hi | (mag[LEN_W-1:0] > room_left[LEN_W-1:0])));
        seek_word  = neg ? ~{1'b0, mag} : {1'b0, mag};
        seek_value = seek_word + POS_W'(neg);
    end

    // Old position range check and load address check.
    always_comb
    begin
        pos_lo    = old_position_reg[CW-1:0];
        in_range  = (old_position_reg[POS_W-1:CW] == '0) && (pos_lo < CW'(old_length_reg)) &&
                    (pos_lo < CW'(OLD_DEPTH));
        load_addr = CW'(cmd.old_address);
    end

    // Next state for the triple sequencer and positions.
    always_comb
    begin
        slot_next           = slot_reg;
        add_remaining_next  = add_remaining_reg;
        copy_remaining_next = copy_remaining_reg;
        pending_seek_next   = pending_seek_reg;
        new_position_next   = new_position_reg;
        failed_next         = failed_reg;
        pos_operand         = '0;
        pos_cin             = 1'b0;
        pos_update          = 1'b0;
        mem_we              = 1'b0;
        res_valid           = 1'b0;
        res_status          = ST_OK;
        res_patch           = '0;
        res_use_old         = 1'b0;
        res_last            = 1'b0;
        run_done            = 1'b0;

        if (cmd_acc)
        begin
            case (cmd.func)
                FUNC_LOAD:
                begin
                    mem_we = (load_addr < CW'(OLD_DEPTH));
                end
                FUNC_CTRL:
                begin
                    res_valid = 1'b1;
                    if (failed_reg)
                    begin
                        res_status = ST_CORRUPT;
                    end
                    else if (slot_reg == SLOT_DATA || (slot_reg == SLOT_ADD && room == '0))
                    begin
                        res_status = ST_TURN;
                    end
                    else
                    begin
                        case (slot_reg)
                            SLOT_ADD:
                            begin
                                if (slot0_bad)
                                begin
                                    res_status  = ST_CORRUPT;
                                    failed_next = 1'b1;
                                end
                                else
                                begin
                                    res_valid          = 1'b0;
                                    add_remaining_next = mag[LEN_W-1:0];
                                    slot_next          = SLOT_COPY;
                                end
                            end
                            SLOT_COPY:
                            begin
                                if (slot1_bad)
                                begin
                                    res_status  = ST_CORRUPT;
                                    failed_next = 1'b1;
                                end
                                else
                                begin
                                    res_valid           = 1'b0;
                                    copy_remaining_next = mag[LEN_W-1:0];
                                    slot_next           = SLOT_SEEK;
                                end
                            end
                            default:
                            begin
                                // Seek word: an empty triple applies the seek at once.
                                res_valid         = 1'b0;
                                pending_seek_next = seek_value;
                                if (add_remaining_reg == '0 && copy_remaining_reg == '0)
                                begin
                                    pos_update  = 1'b1;
                                    pos_operand = seek_word;
                                    pos_cin     = neg;
                                    slot_next   = SLOT_ADD;
                                end
                                else
                                begin
                                    slot_next = SLOT_DATA;
                                end
                            end
                        endcase
                    end
                end
                FUNC_DATA:
                begin
                    res_valid = 1'b1;
                    if (failed_reg)
                    begin
                        res_status = ST_CORRUPT;
                    end
                    else if (slot_reg != SLOT_DATA)
                    begin
                        res_status = ST_TURN;
                    end
                    else
                    begin
                        res_patch  = cmd.patch_byte;
                        pos_update = 1'b1;
                        if (add_remaining_reg != '0)
                        begin
                            // Add phase: consume one old byte.
                            res_use_old        = in_range;
                            add_remaining_next = add_remaining_reg - LEN_W'(1);
                            pos_cin            = 1'b1;
                            run_done = (add_remaining_reg == LEN_W'(1)) &&
                                       (copy_remaining_reg == '0);
                        end
                        else
                        begin
                            // Copy phase: pass the byte through.
                            if (copy_remaining_reg != '0)
                            begin
                                copy_remaining_next = copy_remaining_reg - LEN_W'(1);
                            end
                            run_done = (copy_remaining_reg <= LEN_W'(1));
                        end
                        if (run_done)
                        begin
                            pos_operand = pending_seek_reg;
                            slot_next   = SLOT_ADD;
                        end
                        new_position_next = new_position_reg + LEN_W'(1);
                        res_last          = (new_position_next == new_length_reg);
                    end
                end
                default:
                begin
                    res_valid  = 1'b1;
                    res_status = ST_TURN;
                end
            endcase
        end

        // One adder moves the old position by one, by the seek, or both.
        old_position_next = pos_update ?
                            (old_position_reg + pos_operand + POS_W'(pos_cin)) :
                            old_position_reg;
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg           <= SLOT_ADD;
            add_remaining_reg  <= '0;
            copy_remaining_reg <= '0;
            pending_seek_reg   <= '0;
            old_position_reg   <= '0;
            new_position_reg   <= '0;
            failed_reg         <= 1'b0;
        end
        else
        begin
            slot_reg           <= slot_next;
            add_remaining_reg  <= add_remaining_next;
            copy_remaining_reg <= copy_remaining_next;
            pending_seek_reg   <= pending_seek_next;
            old_position_reg   <= old_position_next;
            new_position_reg   <= new_position_next;
            failed_reg         <= failed_next;
        end
    end

    // Old image memory; the read is captured together with stage one.
    dpa_old_mem #(
        .DEPTH (OLD_DEPTH),
        .AW    (AW)
    ) u_old_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (load_addr[AW-1:0]),
        .wr_data (cmd.old_byte),
        .rd_en   (cmd.ready),
        .rd_addr (old_position_reg[AW-1:0]),
        .rd_data (mem_rdata)
    );

    // Stage one and output register valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                s1_valid_reg <= res_valid;
            end
            if (s1_go)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Stage one and output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.ready)
        begin
            s1_status_reg  <= res_status;
            s1_patch_reg   <= res_patch;
            s1_use_old_reg <= res_use_old;
            s1_last_reg    <= res_last;
        end
        if (s1_go)
        begin
            out_byte_reg   <= s1_patch_reg + (s1_use_old_reg ? mem_rdata : '0);
            out_status_reg <= s1_status_reg;
            out_last_reg   <= s1_last_reg;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;
    assign result.status   = out_status_reg;
    assign result.last     = out_last_reg;

endmodule

FILE: sv/dpa_old_mem.sv
// Old image store: one write port and one registered read port.
`timescale 1ns / 1ps

module dpa_old_mem import dpa_pkg::*; #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem_array [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // Write and registered read; contents are undefined until loaded.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/dpa_checker.sv
// Port-level assertions for the delta patch applier and their bind.
`timescale 1ns / 1ps

module dpa_checker import dpa_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_ready,
    input func_t             cmd_func,
    input logic              res_valid,
    input logic              res_ready,
    input logic [BYTE_W-1:0] res_byte,
    input status_t           res_status,
    input logic              res_last
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_byte) &&
        $stable(res_status) && $stable(res_last))
    else $error("result changed while stalled");

    // An error result carries no byte and no end mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != ST_OK |-> res_byte == '0 && !res_last)
    else $error("error result with payload");

    // The input side never waits while the output side takes results.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_ready |-> cmd_ready)
    else $error("input stalled while output is free");

    // A reserved item passes through stage one to the output with a turn status when nothing blocks it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && cmd_func == FUNC_RSVD) ##1 res_ready |=>
        res_valid && res_status == ST_TURN)
    else $error("reserved item lost or wrong status");

endmodule

bind delta_patch_apply dpa_checker u_dpa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .cmd_func   (cmd.func),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_byte   (result.out_byte),
    .res_status (result.status),
    .res_last   (result.last)
);
